FILE: rtl/bipr_pkg.sv
// Shared types and constants for the binary isolated-pixel removal core.
// No dependencies; used by bipr_cfg and the core top level.
`timescale 1ns / 1ps

package bipr_pkg;

  // field widths
  localparam int FW_W     = 11;
  localparam int FH_W     = 16;
  localparam int MW_W     = 4;
  localparam int ROW_W    = 16;
  localparam int OCOL_W   = 10;
  localparam int APB_AW   = 4;
  localparam int APB_DW   = 32;
  localparam int S_DATA_W = 8;
  localparam int M_DATA_W = 32;

  // register reset values and lower limits
  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 16'd480;
  localparam logic [MW_W-1:0] MIN_WHITE_RST    = 4'd2;
  localparam logic [FW_W-1:0] WIDTH_MIN        = 11'd3;
  localparam logic [FH_W-1:0] HEIGHT_MIN       = 16'd3;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_MIN_WHITE    = 2'd2
  } reg_idx_t;

  // effective frame geometry seen by the datapath
  typedef struct packed {
    logic [FW_W-1:0] width;
    logic [FW_W-1:0] width_last;
    logic [FH_W-1:0] height;
    logic [FH_W-1:0] height_last;
    logic [MW_W-1:0] min_white;
  } cfg_t;

endpackage

FILE: rtl/bipr_cfg.sv
// APB register block: frame_width, frame_height, min_white.
// Keeps the raw values for readback and the clamped geometry as bipr_pkg::cfg_t.
`timescale 1ns / 1ps

module bipr_cfg #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bipr_pkg::APB_AW-1:0]      paddr,
  input  logic [bipr_pkg::APB_DW-1:0]      pwdata,
  output logic [bipr_pkg::APB_DW-1:0]      prdata,
  output logic                             pready,
  output bipr_pkg::cfg_t                   cfg
);

  logic [bipr_pkg::FW_W-1:0] frame_width;
  logic [bipr_pkg::FH_W-1:0] frame_height;
  logic [bipr_pkg::MW_W-1:0] min_white;
  bipr_pkg::cfg_t            cfg_q;
  bipr_pkg::reg_idx_t        idx;
  logic                      wr_en;
  logic [bipr_pkg::FW_W-1:0] wr_width;
  logic [bipr_pkg::FH_W-1:0] wr_height;
  logic [bipr_pkg::FW_W-1:0] rst_width;

  function automatic logic [bipr_pkg::FW_W-1:0] clamp_width(input logic [bipr_pkg::FW_W-1:0] v);
    logic [bipr_pkg::FW_W-1:0] r;
    r = v;
    if (int'(v) > MAX_WIDTH) r = bipr_pkg::FW_W'(MAX_WIDTH);
    if (v < bipr_pkg::WIDTH_MIN) r = bipr_pkg::WIDTH_MIN;
    return r;
  endfunction

  function automatic logic [bipr_pkg::FH_W-1:0] clamp_height(input logic [bipr_pkg::FH_W-1:0] v);
    return (v < bipr_pkg::HEIGHT_MIN) ? bipr_pkg::HEIGHT_MIN : v;
  endfunction

  assign pready    = 1'b1;
  assign idx       = bipr_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en     = psel && penable && pwrite;
  assign wr_width  = clamp_width(pwdata[bipr_pkg::FW_W-1:0]);
  assign wr_height = clamp_height(pwdata[bipr_pkg::FH_W-1:0]);
  assign rst_width = clamp_width(bipr_pkg::FRAME_WIDTH_RST);
  assign cfg       = cfg_q;

  // clamped copies are written on the same edge as the raw register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width       <= bipr_pkg::FRAME_WIDTH_RST;
      frame_height      <= bipr_pkg::FRAME_HEIGHT_RST;
      min_white         <= bipr_pkg::MIN_WHITE_RST;
      cfg_q.width       <= rst_width;
      cfg_q.width_last  <= rst_width - 11'd1;
      cfg_q.height      <= bipr_pkg::FRAME_HEIGHT_RST;
      cfg_q.height_last <= bipr_pkg::FRAME_HEIGHT_RST - 16'd1;
      cfg_q.min_white   <= bipr_pkg::MIN_WHITE_RST;
    end else if (wr_en) begin
      unique case (idx)
        bipr_pkg::REG_FRAME_WIDTH: begin
          frame_width      <= pwdata[bipr_pkg::FW_W-1:0];
          cfg_q.width      <= wr_width;
          cfg_q.width_last <= wr_width - 11'd1;
        end
        bipr_pkg::REG_FRAME_HEIGHT: begin
          frame_height      <= pwdata[bipr_pkg::FH_W-1:0];
          cfg_q.height      <= wr_height;
          cfg_q.height_last <= wr_height - 16'd1;
        end
        bipr_pkg::REG_MIN_WHITE: begin
          min_white       <= pwdata[bipr_pkg::MW_W-1:0];
          cfg_q.min_white <= pwdata[bipr_pkg::MW_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bipr_pkg::REG_FRAME_WIDTH:  prdata = bipr_pkg::APB_DW'(frame_width);
      bipr_pkg::REG_FRAME_HEIGHT: prdata = bipr_pkg::APB_DW'(frame_height);
      bipr_pkg::REG_MIN_WHITE:    prdata = bipr_pkg::APB_DW'(min_white);
      default:                    prdata = '0;
    endcase
  end

endmodule

FILE: rtl/binary_isolated_pixel_removal_core.sv
// Binary isolated-pixel removal: a 3x3 window clear of row 0 and column 0 is kept when it
// holds at least min_white set pixels; a pixel survives only when some kept window covers it.
// Output lags input by two rows and two columns. One pixel beat is taken per clock while
// s_tready is high. Pixels in the first two rows or the first two columns yield no result;
// from there a pixel yields one result beat, a pixel at the end of a row three, every other
// pixel of the last row three, and the last pixel of the frame nine; the input is held while
// the extra beats go out, since the emit stage hands one beat per clock to the output register
// while the output is not stalled. A result beat is registered in stage 1, stage 2 and then the output register.
// Two line stores of MAX_WIDTH x 2 bits hold the previous two pixel rows and window-flag rows;
// they are not cleared; entries left from an earlier frame may be read but are masked out.
// Depends on bipr_pkg and bipr_cfg.
`timescale 1ns / 1ps

module binary_isolated_pixel_removal_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  // bit 0: pixel_in
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [bipr_pkg::S_DATA_W-1:0]   s_tdata,
  // bit 0: start_of_frame
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // bit 0: pixel_out, bits 16:1: out_row, bits 26:17: out_col
  output logic [bipr_pkg::M_DATA_W-1:0]   m_tdata,
  output logic                            m_tlast,
  // bit 0: end_of_frame
  output logic                            m_tuser,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bipr_pkg::APB_AW-1:0]     paddr,
  input  logic [bipr_pkg::APB_DW-1:0]     pwdata,
  output logic [bipr_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int XW = (CW + 1 > bipr_pkg::FW_W) ? CW + 1 : bipr_pkg::FW_W;
  localparam int RW = bipr_pkg::ROW_W;

  bipr_pkg::cfg_t cfg;

  // position counters
  logic [CW-1:0] col_cnt, col_next, x0;
  logic [RW-1:0] row_cnt, row_next, y0;
  logic [RW:0]   row_s;
  logic [CW-1:0] col_s;
  logic          row_end0, last_row0;
  logic          in_acc;

  // line stores
  logic [1:0] pix_mem  [MAX_WIDTH];
  logic [1:0] flag_mem [MAX_WIDTH];
  logic [1:0] prd, frd;

  // stage 1
  logic          s1_valid, s1_pix, s1_row_end, s1_last_row, s1_adv;
  logic [CW-1:0] s1_x, faddr;
  logic [RW-1:0] s1_y;
  logic [2:0]    pcol;
  logic [2:0][2:0] pnb, p_next;   // [col][row], col 0 oldest, row 0 oldest
  logic [3:0]    win_cnt;
  logic          s1_flag, s1_emit;
  logic [2:0]    s1_rmask, s1_cmask;

  // stage 2 (emit)
  logic          s2_valid, s2_emit, s2_flag, s2_row_end, s2_last_row, s2_done, s2_free;
  logic [2:0]    s2_rmask, s2_cmask;
  logic [RW-1:0] s2_row0;
  logic [CW-1:0] s2_col0;
  logic [2:0][2:0] fnb, f_next;
  logic [2:0]    fcol;
  logic [1:0]    a_idx, b_idx, a_max, b_max;
  logic          cov, is_last, out_pix, out_eof;
  logic [RW-1:0] out_row;
  logic [bipr_pkg::OCOL_W-1:0] out_col;

  // output register
  logic out_free, out_load;

  bipr_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------- input side: position of the incoming pixel
  assign in_acc   = s_tvalid && s_tready;
  assign s2_free  = !s2_valid || s2_done;
  assign s1_adv   = s1_valid && s2_free;
  assign s_tready = !s1_valid || s2_free;

  always_comb begin
    col_s = s_tuser ? '0 : col_cnt;
    row_s = s_tuser ? '0 : {1'b0, row_cnt};
    // geometry may have shrunk since the counters were last advanced
    if (XW'(col_s) >= XW'(cfg.width)) begin
      col_s = '0;
      row_s = row_s + 17'd1;
    end
    if (row_s >= {1'b0, cfg.height}) row_s = '0;
    x0        = col_s;
    y0        = row_s[RW-1:0];
    row_end0  = (XW'(x0) == XW'(cfg.width_last));
    last_row0 = (y0 == cfg.height_last);
    if (row_end0) begin
      col_next = '0;
      row_next = last_row0 ? '0 : y0 + 16'd1;
    end else begin
      col_next = x0 + CW'(1);
      row_next = y0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        col_cnt <= col_next;
        row_cnt <= row_next;
      end
      if (in_acc) s1_valid <= 1'b1;
      else if (s1_adv) s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix      <= s_tdata[0];
      s1_x        <= x0;
      s1_y        <= y0;
      s1_row_end  <= row_end0;
      s1_last_row <= last_row0;
    end
  end

  // pixel line store: [1] row y-1, [0] row y-2 at read time
  always_ff @(posedge clk) begin
    if (in_acc) prd <= pix_mem[x0];
    if (s1_adv) pix_mem[s1_x] <= {s1_pix, prd[1]};
  end

  // ---------------- stage 1: window count and flag
  always_comb begin
    pcol     = {s1_pix, prd[1], prd[0]};
    p_next   = {pcol, pnb[2], pnb[1]};
    win_cnt  = 4'($countones(p_next));
    s1_flag  = (s1_y >= 16'd3) && (s1_x >= CW'(3)) && (win_cnt >= cfg.min_white);
    s1_emit  = (s1_y >= 16'd2) && (s1_x >= CW'(2));
    // window rows/cols above or left of index 1 never count
    s1_rmask = {s1_y >= 16'd3, s1_y >= 16'd4, s1_y >= 16'd5};
    s1_cmask = {s1_x >= CW'(3), s1_x >= CW'(4), s1_x >= CW'(5)};
    faddr    = (s1_x >= CW'(2)) ? s1_x - CW'(2) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pnb      <= '0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_adv) pnb <= p_next;
      if (s1_adv) s2_valid <= 1'b1;
      else if (s2_done) s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_emit     <= s1_emit;
      s2_flag     <= s1_flag;
      s2_rmask    <= s1_rmask;
      s2_cmask    <= s1_cmask;
      s2_row0     <= s1_y - 16'd2;
      s2_col0     <= faddr;
      s2_row_end  <= s1_row_end;
      s2_last_row <= s1_last_row;
    end
  end

  // flag line store: [1] window row y-3, [0] row y-4 at read time
  always_ff @(posedge clk) begin
    if (s1_adv) frd <= flag_mem[faddr];
    if (s2_done && s2_emit) flag_mem[s2_col0] <= {s2_flag, frd[1]};
  end

  // ---------------- stage 2: coverage and result sequencing
  always_comb begin
    fcol   = {s2_flag, frd[1], frd[0]};
    f_next = {fcol, fnb[2], fnb[1]};
    a_max  = s2_last_row ? 2'd2 : 2'd0;
    b_max  = s2_row_end ? 2'd2 : 2'd0;
    // result (a,b) sits a rows below and b cols right of the base pixel; windows
    // at flag index below a or b do not reach it
    cov = 1'b0;
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        if (j >= int'(b_idx) && i >= int'(a_idx))
          cov = cov | (f_next[j][i] & s2_rmask[i] & s2_cmask[j]);
      end
    end
    out_pix = pnb[b_idx][a_idx] & cov;
    out_row = s2_row0 + {14'd0, a_idx};
    out_col = bipr_pkg::OCOL_W'(s2_col0 + CW'(b_idx));
    is_last = (a_idx == a_max) && (b_idx == b_max);
    out_eof = s2_last_row && s2_row_end && (a_idx == 2'd2) && (b_idx == 2'd2);
  end

  assign out_free = !m_tvalid || m_tready;
  assign out_load = s2_valid && s2_emit && out_free;
  assign s2_done  = s2_valid && (!s2_emit || (out_free && is_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      fnb      <= '0;
      a_idx    <= '0;
      b_idx    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (s2_done) fnb <= f_next;
      if (s2_done) begin
        a_idx <= '0;
        b_idx <= '0;
      end else if (out_load) begin
        if (b_idx == b_max) begin
          b_idx <= '0;
          a_idx <= a_idx + 2'd1;
        end else begin
          b_idx <= b_idx + 2'd1;
        end
      end
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {5'd0, out_col, out_row, out_pix};
      m_tlast <= is_last;
      m_tuser <= out_eof;
    end
  end

endmodule

FILE: rtl/bipr_checker.sv
// Port-level checks for the isolated-pixel removal core, bound to the top level.
// Depends only on the top-level port list.
`timescale 1ns / 1ps

module bipr_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser,
  input logic        pready
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // frame end is the last beat of its input pixel
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("end of frame without tlast");

  // row 0 and column 0 never hold a kept pixel
  a_border: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> (m_tdata[16:1] != 16'd0) && (m_tdata[26:17] != 10'd0))
    else $error("kept pixel on frame border");

  // beats of one input pixel follow without a gap
  a_burst: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("gap inside a result burst");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && pready)
    else $error("output valid after reset");

endmodule

bind binary_isolated_pixel_removal_core bipr_checker u_bipr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser),
  .pready   (pready)
);
